### hw/rtl/tcwu_pkg.sv
// Package for the congestion window update core: field widths, reset values,
// event and register codes, and the command and status bundles between the
// controller and the datapath. No dependencies.
package tcwu_pkg;

   localparam int OP_W    = 2;
   localparam int ACK_W   = 15;
   localparam int SEG_W   = 13;
   localparam int CFG_W   = 16;
   localparam int WIN_W   = 20;
   localparam int SQ_W    = 2 * SEG_W;
   localparam int IDX_W   = 2;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 48;

   localparam int SEQ_SPACE_DEF = 25600;
   localparam int ACK_MAX       = (1 << ACK_W) - 1;

   localparam logic [WIN_W-1:0] WIN_MAX        = {WIN_W{1'b1}};
   localparam logic [SEG_W-1:0] SEG_RST        = 13'd512;
   localparam logic [CFG_W-1:0] INIT_WIN_RST   = 16'd512;
   localparam logic [CFG_W-1:0] INIT_THR_RST   = 16'd5120;
   localparam logic [CFG_W-1:0] THR_FLOOR_RST  = 16'd1024;
   localparam logic [WIN_W-1:0] CWND_RST       = 20'd512;
   localparam logic [WIN_W-1:0] SSTHR_RST      = 20'd5120;

   localparam int DIV_STEPS = SQ_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [OP_W-1:0] OP_ACK     = 2'd0;
   localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   localparam logic [IDX_W-1:0] REG_SEGMENT_SIZE      = 2'd0;
   localparam logic [IDX_W-1:0] REG_INITIAL_WINDOW    = 2'd1;
   localparam logic [IDX_W-1:0] REG_INITIAL_THRESHOLD = 2'd2;
   localparam logic [IDX_W-1:0] REG_THRESHOLD_FLOOR   = 2'd3;

   typedef struct packed {
      logic load;
      logic eval;
      logic grow;
      logic div_start;
      logic div_step;
      logic div_apply;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic is_ack;
      logic need_div;
   } status_type;

   // number of compare-subtract steps that reduce any ACK value below seq_space
   function automatic int mod_steps(input int seq_space);
      int k;
      k = 0;
      for (int j = 0; j < ACK_W + 1; j++) begin
         if ((seq_space << j) <= ACK_MAX) begin
            k = j + 1;
         end
      end
      return k;
   endfunction

endpackage

### hw/rtl/tcwu_ctrl.sv
// Controller state machine of the congestion window update core.
// Sequences event evaluation, window growth and the divider.
// Depends on tcwu_pkg.
module tcwu_ctrl
   import tcwu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_GROW,
      S_DIV,
      S_APPLY,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic                 valid_ff, valid_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 can_load;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign can_load   = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = rsp_tready ? 1'b0 : valid_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.is_ack ? S_GROW : S_DONE;
         end
         S_GROW: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               cnt_in        = DIV_CNT_W'(DIV_STEPS - 1);
               state_in      = S_DIV;
            end else begin
               cmd.grow = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.div_apply = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (can_load) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### hw/rtl/tcwu_datapath.sv
// Datapath of the congestion window update core: configuration registers,
// window state, ACK history, restoring divider and the result register.
// Depends on tcwu_pkg.
module tcwu_datapath
   import tcwu_pkg::*;
#(
   parameter int SEQ_SPACE = SEQ_SPACE_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [IDX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]       csr_wr_data,
   input  logic [OP_W-1:0]        req_opcode,
   input  logic [ACK_W-1:0]       req_ack_number,
   input  cmd_type                cmd,
   output status_type             status,
   output logic [WIN_W-1:0]       rsp_window,
   output logic [WIN_W-1:0]       rsp_threshold,
   output logic                   rsp_mode,
   output logic                   rsp_fast_retransmit
);

   localparam int MOD_STEPS = mod_steps(SEQ_SPACE);

   logic [SEG_W-1:0] seg_ff;
   logic [CFG_W-1:0] iwin_ff, ithr_ff, floor_ff;

   logic [OP_W-1:0]  op_ff;
   logic [ACK_W-1:0] ack_ff;
   logic [ACK_W-1:0] hist_ff [3];
   logic [WIN_W-1:0] cwnd_ff, thr_ff;
   logic             mode_ff, fr_ff;

   logic [WIN_W-1:0] rem_ff, dvs_ff;
   logic [SQ_W-1:0]  quo_ff;

   logic [WIN_W-1:0] win_out_ff, thr_out_ff;
   logic             mode_out_ff, fr_out_ff;

   logic [ACK_W:0]   ack_red;
   logic [WIN_W-1:0] halved;
   logic             triple;
   logic [WIN_W:0]   ss_sum;
   logic [SQ_W:0]    ca_sum;
   logic [WIN_W:0]   rem_sh;
   logic             rem_ge;

   // reduce the ACK number into the sequence space
   always_comb begin
      ack_red = {1'b0, req_ack_number};
      for (int i = MOD_STEPS - 1; i >= 0; i--) begin
         if (ack_red >= ((ACK_W + 1)'(SEQ_SPACE) << i)) begin
            ack_red = ack_red - ((ACK_W + 1)'(SEQ_SPACE) << i);
         end
      end
   end

   assign halved = ({1'b0, cwnd_ff[WIN_W-1:1]} > WIN_W'(floor_ff))
                   ? {1'b0, cwnd_ff[WIN_W-1:1]} : WIN_W'(floor_ff);
   assign triple = (hist_ff[1] == hist_ff[2]) && (hist_ff[2] == ack_ff);
   assign ss_sum = {1'b0, cwnd_ff} + (WIN_W + 1)'(seg_ff);
   assign ca_sum = (SQ_W + 1)'(cwnd_ff) + {1'b0, quo_ff};
   assign rem_sh = {rem_ff, quo_ff[SQ_W-1]};
   assign rem_ge = rem_sh >= {1'b0, dvs_ff};

   assign status.is_ack   = (op_ff == OP_ACK);
   assign status.need_div = mode_ff && (cwnd_ff >= thr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff   <= SEG_RST;
         iwin_ff  <= INIT_WIN_RST;
         ithr_ff  <= INIT_THR_RST;
         floor_ff <= THR_FLOOR_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_SEGMENT_SIZE:      seg_ff   <= csr_wr_data[SEG_W-1:0];
            REG_INITIAL_WINDOW:    iwin_ff  <= csr_wr_data;
            REG_INITIAL_THRESHOLD: ithr_ff  <= csr_wr_data;
            REG_THRESHOLD_FLOOR:   floor_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cwnd_ff    <= CWND_RST;
         thr_ff     <= SSTHR_RST;
         mode_ff    <= 1'b0;
         fr_ff      <= 1'b0;
         hist_ff[0] <= '0;
         hist_ff[1] <= '0;
         hist_ff[2] <= '0;
      end else begin
         if (cmd.eval) begin
            fr_ff <= 1'b0;
            case (op_ff)
               OP_ACK: begin
                  hist_ff[0] <= hist_ff[1];
                  hist_ff[1] <= hist_ff[2];
                  hist_ff[2] <= ack_ff;
                  if (triple) begin
                     thr_ff  <= halved;
                     cwnd_ff <= halved;
                     mode_ff <= 1'b1;
                     fr_ff   <= 1'b1;
                  end
               end
               OP_TIMEOUT: begin
                  thr_ff  <= halved;
                  cwnd_ff <= WIN_W'(seg_ff);
                  mode_ff <= 1'b0;
               end
               OP_RESTART: begin
                  cwnd_ff    <= WIN_W'(iwin_ff);
                  thr_ff     <= WIN_W'(ithr_ff);
                  mode_ff    <= 1'b0;
                  hist_ff[0] <= '0;
                  hist_ff[1] <= '0;
                  hist_ff[2] <= '0;
               end
               default: ;
            endcase
         end
         if (cmd.grow && !mode_ff) begin
            if (cwnd_ff < thr_ff) begin
               cwnd_ff <= ss_sum[WIN_W] ? WIN_MAX : ss_sum[WIN_W-1:0];
            end else begin
               mode_ff <= 1'b1;
            end
         end
         if (cmd.div_apply) begin
            cwnd_ff <= (ca_sum > (SQ_W + 1)'(WIN_MAX)) ? WIN_MAX : ca_sum[WIN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         ack_ff <= ack_red[ACK_W-1:0];
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= SQ_W'(seg_ff) * SQ_W'(seg_ff);
         dvs_ff <= (cwnd_ff == '0) ? WIN_W'(1) : cwnd_ff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? WIN_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[WIN_W-1:0];
         quo_ff <= {quo_ff[SQ_W-2:0], rem_ge};
      end
      if (cmd.out_load) begin
         win_out_ff  <= cwnd_ff;
         thr_out_ff  <= thr_ff;
         mode_out_ff <= mode_ff;
         fr_out_ff   <= fr_ff;
      end
   end

   assign rsp_window          = win_out_ff;
   assign rsp_threshold       = thr_out_ff;
   assign rsp_mode            = mode_out_ff;
   assign rsp_fast_retransmit = fr_out_ff;

endmodule

### hw/rtl/tcp_congestion_window_update_core.sv
// Top level of the congestion window update core: joins the controller and
// the datapath and maps the stream and register ports. Depends on tcwu_pkg,
// tcwu_ctrl and tcwu_datapath.
//
// Usage: each beat on the req_ channel is one event (ACK, timeout, restart;
// the event code rides in req_tuser). Each event yields exactly one beat on
// the rsp_ channel carrying window, threshold, mode and fast-retransmit flag.
// One event is in work at a time. Timeout, restart and unused events pass
// from evaluation straight to the done state, where the result loads; an ACK
// that does not grow by division passes through the grow state as well. An
// ACK in congestion avoidance runs the restoring divider for segment squared
// over window, one quotient bit per cycle over 26 bits, and adds the quotient
// to the window. The next event is taken the cycle after the result loads.
// The result sits in an output register; the next event is accepted while it
// waits. When the receiver stalls, a finished result holds the core until
// the previous one is taken. Synchronous reset loads the default registers,
// a window of 512, a threshold of 5120, slow start and a zero ACK history;
// no clearing pass is needed. Write csr_ registers only while idle.
module tcp_congestion_window_update_core
   import tcwu_pkg::*;
#(
   parameter int SEQ_SPACE = SEQ_SPACE_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [IDX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]       csr_wr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // ack_number[14:0], zero [15]
   input  logic [OP_W-1:0]        req_tuser,   // opcode[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // window[19:0], threshold[39:20],
                                               // mode[40], fast_retransmit[41], zero
);

   cmd_type          cmd;
   status_type       status;
   logic [WIN_W-1:0] rsp_window, rsp_threshold;
   logic             rsp_mode, rsp_fast_retransmit;

   tcwu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcwu_datapath #(
      .SEQ_SPACE (SEQ_SPACE)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_opcode          (req_tuser),
      .req_ack_number      (req_tdata[ACK_W-1:0]),
      .cmd                 (cmd),
      .status              (status),
      .rsp_window          (rsp_window),
      .rsp_threshold       (rsp_threshold),
      .rsp_mode            (rsp_mode),
      .rsp_fast_retransmit (rsp_fast_retransmit)
   );

   assign rsp_tdata = {6'b0, rsp_fast_retransmit, rsp_mode, rsp_threshold, rsp_window};

endmodule

### tb/tb_top.sv
// Testbench for tcp_congestion_window_update_core: streams ACK, timeout and restart
// events, tracks window, threshold and mode in its own model and checks each result
// beat field by field. Depends on tcwu_pkg and the core RTL.
module tb_top;
   import tcwu_pkg::*;

   localparam int SEQ_SPACE    = SEQ_SPACE_DEF;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_EVENTS = 350;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [ACK_W-1:0] ack_number;
   } event_type;

   // packed from the top down so that window lands in the low bits
   typedef struct packed {
      logic             fast_retransmit;
      logic             mode;
      logic [WIN_W-1:0] threshold;
      logic [WIN_W-1:0] window;
   } cwnd_result_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [IDX_W-1:0]       csr_index   = '0;
   logic [CFG_W-1:0]       csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;   // ack_number[14:0], zero [15]
   logic [OP_W-1:0]        req_tuser   = '0;   // opcode[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;          // window[19:0], threshold[39:20],
                                               // mode[40], fast_retransmit[41], zero

   logic [SEG_W-1:0] seg_size     = SEG_RST;
   logic [CFG_W-1:0] init_window  = INIT_WIN_RST;
   logic [CFG_W-1:0] init_thresh  = INIT_THR_RST;
   logic [CFG_W-1:0] thresh_floor = THR_FLOOR_RST;
   logic [WIN_W-1:0] cwnd         = CWND_RST;
   logic [WIN_W-1:0] ssthresh     = SSTHR_RST;
   logic             ca_mode      = 1'b0;
   logic [ACK_W-1:0] ack_hist [3] = '{default: '0};

   event_type       queued_events [$];
   cwnd_result_type predicted_windows [$];
   event_type       cur_event;
   cwnd_result_type got_window;
   cwnd_result_type want_window;

   bit          idling_on    = 1'b0;
   int unsigned send_gap     = 0;
   int unsigned hold_cycles  = 0;
   int unsigned events_total = 0;
   int unsigned results_seen = 0;
   int unsigned error_count  = 0;
   int unsigned cycle_count  = 0;

   tcp_congestion_window_update_core #(
      .SEQ_SPACE(SEQ_SPACE)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic logic [WIN_W-1:0] halve_floor(input logic [WIN_W-1:0] w);
      logic [WIN_W-1:0] h;
      h = w >> 1;
      return (h > WIN_W'(thresh_floor)) ? h : WIN_W'(thresh_floor);
   endfunction

   function automatic logic [WIN_W-1:0] sat_add(input longint unsigned a,
                                                input longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > longint'(WIN_MAX)) ? WIN_MAX : WIN_W'(s);
   endfunction

   function automatic cwnd_result_type update_cwnd(input event_type ev);
      cwnd_result_type  res;
      logic [ACK_W-1:0] ack;
      longint unsigned  seg_sq;
      longint unsigned  divisor;
      res.fast_retransmit = 1'b0;
      case (ev.opcode)
         OP_ACK: begin
            ack = ACK_W'(ev.ack_number % SEQ_SPACE);
            ack_hist[0] = ack_hist[1];
            ack_hist[1] = ack_hist[2];
            ack_hist[2] = ack;
            if (ack_hist[0] == ack_hist[1] && ack_hist[1] == ack_hist[2]) begin
               ssthresh = halve_floor(cwnd);
               cwnd = ssthresh;
               ca_mode = 1'b1;
               res.fast_retransmit = 1'b1;
            end
            if (!ca_mode) begin
               if (cwnd < ssthresh) cwnd = sat_add(cwnd, seg_size);
               else ca_mode = 1'b1;
            end else if (cwnd >= ssthresh) begin
               seg_sq = longint'(seg_size) * longint'(seg_size);
               divisor = (cwnd == '0) ? 1 : longint'(cwnd);
               cwnd = sat_add(cwnd, seg_sq / divisor);
            end
         end
         OP_TIMEOUT: begin
            ssthresh = halve_floor(cwnd);
            cwnd = WIN_W'(seg_size);
            ca_mode = 1'b0;
         end
         OP_RESTART: begin
            cwnd = WIN_W'(init_window);
            ssthresh = WIN_W'(init_thresh);
            ca_mode = 1'b0;
            ack_hist = '{default: '0};
         end
         default: ;
      endcase
      res.window = cwnd;
      res.threshold = ssthresh;
      res.mode = ca_mode;
      return res;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idling_on || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // driver: predict on each accepted beat, then present the next queued event
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_windows.push_back(update_cwnd(cur_event));
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (queued_events.size() > 0) begin
               cur_event = queued_events.pop_front();
               req_tuser <= cur_event.opcode;
               req_tdata <= REQ_TDATA_W'(cur_event.ack_number);
               req_tvalid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result beat against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_window = cwnd_result_type'(rsp_tdata[2*WIN_W+1:0]);
            if (predicted_windows.size() == 0) begin
               $error("result beat with no prediction waiting");
               error_count++;
            end else begin
               want_window = predicted_windows.pop_front();
               results_seen++;
               check_field("window", want_window.window, got_window.window);
               check_field("threshold", want_window.threshold, got_window.threshold);
               check_field("mode", want_window.mode, got_window.mode);
               check_field("fast_retransmit", want_window.fast_retransmit,
                           got_window.fast_retransmit);
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            hold_cycles = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic push_event(input logic [OP_W-1:0] op, input logic [ACK_W-1:0] ack);
      event_type ev;
      ev.opcode = op;
      ev.ack_number = ack;
      queued_events.push_back(ev);
      events_total++;
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      case (idx)
         REG_SEGMENT_SIZE:      seg_size = SEG_W'(value);
         REG_INITIAL_WINDOW:    init_window = value;
         REG_INITIAL_THRESHOLD: init_thresh = value;
         REG_THRESHOLD_FLOOR:   thresh_floor = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input int unsigned seg, input int unsigned iwin,
                             input int unsigned ithr, input int unsigned floor_val);
      write_reg(REG_SEGMENT_SIZE, CFG_W'(seg));
      write_reg(REG_INITIAL_WINDOW, CFG_W'(iwin));
      write_reg(REG_INITIAL_THRESHOLD, CFG_W'(ithr));
      write_reg(REG_THRESHOLD_FLOOR, CFG_W'(floor_val));
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // hold until every queued event has produced its result
   task automatic wait_drained();
      while (results_seen != events_total) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic random_phase(input int unsigned count);
      int unsigned      start;
      int unsigned      r;
      logic [ACK_W-1:0] next_ack;
      start = events_total;
      next_ack = ACK_W'($urandom_range(0, SEQ_SPACE - 1));
      push_event(OP_RESTART, ACK_W'($urandom_range(0, ACK_MAX)));
      while (events_total - start < count) begin
         r = $urandom_range(0, 99);
         if (r < 64) begin
            next_ack = ACK_W'((next_ack + $urandom_range(1, 2000)) % SEQ_SPACE);
            push_event(OP_ACK, next_ack);
         end else if (r < 78) begin
            repeat ($urandom_range(2, 4)) push_event(OP_ACK, next_ack);
         end else if (r < 86) begin
            push_event(OP_TIMEOUT, ACK_W'($urandom_range(0, ACK_MAX)));
         end else if (r < 91) begin
            push_event(OP_RESTART, ACK_W'($urandom_range(0, ACK_MAX)));
         end else if (r < 94) begin
            push_event(OP_UNUSED, ACK_W'($urandom_range(0, ACK_MAX)));
         end else begin
            push_event(OP_ACK, ACK_W'($urandom_range(0, ACK_MAX)));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      idling_on = 1'b0;
      push_event(OP_ACK, 15'd0);
      push_event(OP_ACK, 15'd100);
      push_event(OP_ACK, 15'd612);
      push_event(OP_TIMEOUT, 15'd12345);
      push_event(OP_ACK, 15'd1124);
      push_event(OP_ACK, 15'd1636);
      push_event(OP_ACK, 15'd25600);
      push_event(OP_ACK, ACK_W'(ACK_MAX));
      push_event(OP_ACK, 15'd7167);
      push_event(OP_ACK, 15'd7167);
      push_event(OP_ACK, 15'd16384);
      push_event(OP_UNUSED, 15'd21845);
      push_event(OP_ACK, 15'd10922);
      push_event(OP_RESTART, ACK_W'(ACK_MAX));
      push_event(OP_ACK, 15'd0);
      push_event(OP_ACK, 15'd0);
      push_event(OP_TIMEOUT, 15'd0);
      push_event(OP_TIMEOUT, 15'd25599);
      push_event(OP_UNUSED, 15'd0);
      wait_drained();

      set_config(4096, 65535, 65535, 65535);
      idling_on = 1'b1;
      random_phase(PHASE_EVENTS);
      wait_drained();

      set_config(1, 1, 1, 1);
      random_phase(PHASE_EVENTS);
      wait_drained();

      set_config($urandom_range(1, 4096), $urandom_range(1, 65535),
                 $urandom_range(1, 65535), $urandom_range(1, 8192));
      idling_on = 1'b0;
      random_phase(PHASE_EVENTS);
      wait_drained();

      set_config(4096, 1, 65535, 1);
      idling_on = 1'b1;
      random_phase(PHASE_EVENTS);
      wait_drained();

      set_config(SEG_RST, INIT_WIN_RST, INIT_THR_RST, THR_FLOOR_RST);
      random_phase(PHASE_EVENTS);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_windows.size() != 0) begin
         $error("%0d predicted results never arrived", predicted_windows.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/tcwu_pkg.sv
hw/rtl/tcwu_ctrl.sv
hw/rtl/tcwu_datapath.sv
hw/rtl/tcp_congestion_window_update_core.sv
tb/tb_top.sv
